/* rtl/tasd_pkg.sv */
// Shared types, codes and defaults for the TCP ack storm detector.
// Used by tasd_cmp and tcp_ack_storm_detector; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package tasd_pkg;

	localparam int ENTRIES_DEFAULT = 128;

	localparam logic [31:0] LOCAL_ADDRESS_RESET   = 32'hC0A8858A;
	localparam logic [7:0]  ALARM_THRESHOLD_RESET = 8'd3;
	localparam logic [7:0]  COUNT_MAX             = 8'd255;

	localparam logic REG_LOCAL_ADDRESS   = 1'b0;
	localparam logic REG_ALARM_THRESHOLD = 1'b1;

	localparam logic [1:0] DIR_SENT    = 2'd0;
	localparam logic [1:0] DIR_RECV    = 2'd1;
	localparam logic [1:0] DIR_IGNORED = 2'd2;

	localparam logic [1:0] CONN_Q0 = 2'd0;
	localparam logic [1:0] CONN_Q1 = 2'd1;
	localparam logic [1:0] CONN_Q2 = 2'd2;

	typedef struct packed {
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [31:0] seq_number;
		logic [31:0] ack_number;
	} in_t;

	typedef struct packed {
		logic [1:0] direction;
		logic [6:0] entry_index;
		logic       allocated;
		logic       table_full;
		logic [1:0] conn_state;
		logic [7:0] attack_count;
		logic       storm_alarm;
	} out_t;

	typedef struct packed {
		logic [31:0] peer_address;
		logic [31:0] sent_ack;
		logic [31:0] sent_seq;
		logic [31:0] recv_ack;
		logic [31:0] recv_seq;
		logic [1:0]  conn_status;
		logic [7:0]  attack_counter;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ALLOC,
		ST_UPD_A,
		ST_UPD_B,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage
`default_nettype wire

/* rtl/tasd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module tasd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* rtl/tasd_cmp.sv */
// Shared 32-bit unsigned compare unit: equality and greater-than.
// Depends on tasd_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none
module tasd_cmp (
	input  wire logic [31:0]        a,
	input  wire logic [31:0]        b,
	output tasd_pkg::cmp_res_t      res
);

	always_comb begin
		res.eq = (a == b);
		res.gt = (a > b);
	end

endmodule
`default_nettype wire

/* rtl/tcp_ack_storm_detector.sv */
// Top level of the TCP ack storm detector: APB registers, sequencer, table.
// Depends on tasd_pkg, tasd_ram and tasd_cmp.
//
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    tasd_pkg::in_t  (one packet)
// out       out  out_valid / out_ready  tasd_pkg::out_t (one result)
// config    in   APB psel/penable       paddr[2:0], pwdata/prdata 32 bits
//
// The table scan through the single RAM read port, one entry per cycle,
// sets the transaction length: an ignored packet skips the scan; a hit at
// entry i scans entries 0 to i; a new peer or a full table scans all fill
// entries, fill being the number of entries in use.
// Entries fill in index order, so a fill count marks them valid; no clear
// pass runs after reset. in_ready is low until the result has been taken.
`timescale 1ns / 1ps
`default_nettype none
module tcp_ack_storm_detector #(
	parameter int ENTRIES = tasd_pkg::ENTRIES_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire tasd_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output tasd_pkg::out_t       out_data,
	input  wire logic            psel,
	input  wire logic            penable,
	input  wire logic            pwrite,
	input  wire logic [2:0]      paddr,
	input  wire logic [31:0]     pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	tasd_pkg::state_t   state_q, state_nx;
	logic [31:0]        local_q;
	logic [7:0]         thresh_q;
	logic [CW-1:0]      count_q;
	logic [IW-1:0]      cidx_q, cidx_nx, idx_q, raddr, waddr;
	logic [1:0]         dir_q, dir_in;
	logic [31:0]        peer_q, seq_q, ack_q;
	logic               alloc_q, full_q, ok_q, alarm_q;
	tasd_pkg::entry_t   entry_q, rdata, wdata, new_ent;
	logic               we;
	logic [31:0]        cmp_a, cmp_b;
	tasd_pkg::cmp_res_t cmp;
	logic               last, is_sent;
	logic [7:0]         cnt_sat;
	logic [IW+6:0]      idx_ext;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q  <= tasd_pkg::LOCAL_ADDRESS_RESET;
			thresh_q <= tasd_pkg::ALARM_THRESHOLD_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				tasd_pkg::REG_LOCAL_ADDRESS:   local_q  <= pwdata;
				tasd_pkg::REG_ALARM_THRESHOLD: thresh_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tasd_pkg::REG_LOCAL_ADDRESS:   prdata = local_q;
			tasd_pkg::REG_ALARM_THRESHOLD: prdata = {24'd0, thresh_q};
			default:                       prdata = '0;
		endcase
	end

	// classification
	always_comb begin
		if (in_data.source_address == local_q) begin
			dir_in = tasd_pkg::DIR_SENT;
		end else if (in_data.dest_address == local_q) begin
			dir_in = tasd_pkg::DIR_RECV;
		end else begin
			dir_in = tasd_pkg::DIR_IGNORED;
		end
	end

	assign is_sent = (dir_q == tasd_pkg::DIR_SENT);
	assign cidx_nx = cidx_q + {{(IW-1){1'b0}}, 1'b1};
	assign last    = ((CW'(cidx_q) + {{(CW-1){1'b0}}, 1'b1}) == count_q);
	assign cnt_sat = (entry_q.attack_counter == tasd_pkg::COUNT_MAX) ?
		entry_q.attack_counter : entry_q.attack_counter + 8'd1;

	always_comb begin
		new_ent                = '0;
		new_ent.peer_address   = peer_q;
		new_ent.conn_status    = tasd_pkg::CONN_Q0;
		if (is_sent) begin
			new_ent.sent_ack = ack_q;
			new_ent.sent_seq = seq_q;
		end else begin
			new_ent.recv_ack = ack_q;
			new_ent.recv_seq = seq_q;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tasd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (dir_in == tasd_pkg::DIR_IGNORED) begin
						state_nx = tasd_pkg::ST_OUT;
					end else if (count_q == '0) begin
						state_nx = tasd_pkg::ST_ALLOC;
					end else begin
						state_nx = tasd_pkg::ST_SEARCH;
					end
				end
			end
			tasd_pkg::ST_SEARCH: begin
				if (cmp.eq) begin
					state_nx = tasd_pkg::ST_UPD_A;
				end else if (last) begin
					state_nx = (count_q == CW'(ENTRIES)) ? tasd_pkg::ST_OUT : tasd_pkg::ST_ALLOC;
				end
			end
			tasd_pkg::ST_ALLOC: state_nx = tasd_pkg::ST_OUT;
			tasd_pkg::ST_UPD_A: begin
				if (!is_sent && entry_q.sent_ack != '0 && !cmp.gt) begin
					state_nx = tasd_pkg::ST_UPD_B;
				end else begin
					state_nx = tasd_pkg::ST_WRITE;
				end
			end
			tasd_pkg::ST_UPD_B: state_nx = tasd_pkg::ST_WRITE;
			tasd_pkg::ST_WRITE: state_nx = tasd_pkg::ST_OUT;
			tasd_pkg::ST_OUT: begin
				if (out_ready) begin
					state_nx = tasd_pkg::ST_IDLE;
				end
			end
			default: state_nx = tasd_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		we        = 1'b0;
		wdata     = entry_q;
		waddr     = idx_q;
		raddr     = cidx_nx;
		cmp_a     = ack_q;
		cmp_b     = seq_q;
		case (state_q)
			tasd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				raddr    = '0;
			end
			tasd_pkg::ST_SEARCH: begin
				cmp_a = rdata.peer_address;
				cmp_b = peer_q;
			end
			tasd_pkg::ST_ALLOC: begin
				we    = 1'b1;
				wdata = new_ent;
				waddr = count_q[IW-1:0];
			end
			tasd_pkg::ST_UPD_A: begin
				cmp_a = is_sent ? seq_q : ack_q;
				cmp_b = is_sent ? entry_q.recv_ack : entry_q.sent_seq;
			end
			tasd_pkg::ST_UPD_B: ;
			tasd_pkg::ST_WRITE: we = 1'b1;
			tasd_pkg::ST_OUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tasd_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == tasd_pkg::ST_ALLOC) begin
				count_q <= count_q + {{(CW-1){1'b0}}, 1'b1};
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tasd_pkg::ST_IDLE: begin
				if (in_valid) begin
					dir_q   <= dir_in;
					peer_q  <= (dir_in == tasd_pkg::DIR_SENT) ?
						in_data.dest_address : in_data.source_address;
					seq_q   <= in_data.seq_number;
					ack_q   <= in_data.ack_number;
					cidx_q  <= '0;
					alloc_q <= 1'b0;
					full_q  <= 1'b0;
					ok_q    <= 1'b0;
					alarm_q <= 1'b0;
				end
			end
			tasd_pkg::ST_SEARCH: begin
				if (cmp.eq) begin
					entry_q <= rdata;
					idx_q   <= cidx_q;
					ok_q    <= 1'b1;
				end else if (last) begin
					full_q <= (count_q == CW'(ENTRIES));
				end else begin
					cidx_q <= cidx_nx;
				end
			end
			tasd_pkg::ST_ALLOC: begin
				entry_q <= new_ent;
				idx_q   <= count_q[IW-1:0];
				alloc_q <= 1'b1;
				ok_q    <= 1'b1;
			end
			tasd_pkg::ST_UPD_A: begin
				if (is_sent) begin
					entry_q.sent_ack <= ack_q;
					entry_q.sent_seq <= seq_q;
					if (entry_q.recv_ack != '0) begin
						if (cmp.gt) begin
							if (entry_q.conn_status == tasd_pkg::CONN_Q2) begin
								entry_q.attack_counter <= '0;
							end
							entry_q.conn_status <= tasd_pkg::CONN_Q1;
						end else if (cmp.eq && entry_q.conn_status == tasd_pkg::CONN_Q2) begin
							entry_q.conn_status    <= tasd_pkg::CONN_Q0;
							entry_q.attack_counter <= '0;
						end
					end
				end else begin
					entry_q.recv_ack <= ack_q;
					entry_q.recv_seq <= seq_q;
					if (entry_q.sent_ack != '0 && cmp.gt) begin
						entry_q.attack_counter <= cnt_sat;
						entry_q.conn_status    <= tasd_pkg::CONN_Q2;
						alarm_q <= (entry_q.conn_status == tasd_pkg::CONN_Q2) &&
							(cnt_sat > thresh_q);
					end
				end
			end
			tasd_pkg::ST_UPD_B: begin
				if (!cmp.gt) begin
					if (entry_q.conn_status == tasd_pkg::CONN_Q2) begin
						entry_q.attack_counter <= '0;
					end
					entry_q.conn_status <= tasd_pkg::CONN_Q0;
				end
			end
			default: ;
		endcase
	end

	tasd_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp)
	);

	tasd_ram #(
		.WIDTH (tasd_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result
	assign idx_ext = {7'd0, idx_q};

	always_comb begin
		out_data.direction    = dir_q;
		out_data.entry_index  = ok_q ? idx_ext[6:0] : 7'd0;
		out_data.allocated    = alloc_q;
		out_data.table_full   = full_q;
		out_data.conn_state   = ok_q ? entry_q.conn_status : tasd_pkg::CONN_Q0;
		out_data.attack_count = ok_q ? entry_q.attack_counter : 8'd0;
		out_data.storm_alarm  = ok_q && alarm_q;
	end

	// checks
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("fill count beyond table depth");

	a_full_only_when_filled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.table_full |-> count_q == CW'(ENTRIES))
		else $error("table full reported with free entries");

	a_alloc_at_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.allocated |->
		count_q == CW'(idx_q) + {{(CW-1){1'b0}}, 1'b1})
		else $error("allocated entry is not the last filled one");

	a_alarm_in_q2: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.storm_alarm |->
		out_data.conn_state == tasd_pkg::CONN_Q2 && out_data.attack_count > thresh_q)
		else $error("storm alarm without q2 and counter over threshold");

endmodule
`default_nettype wire
